[sv/lag_pkg.sv]
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types, constants and helper functions for the toroidal Life grid.
// ----------------------------------------------------------------------------
package lag_pkg;

    // Grid geometry
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int ROW_W       = $clog2(GRID_HEIGHT);
    localparam int COL_W       = $clog2(GRID_WIDTH);
    // Two row banks: current generation and the one being built
    localparam int RAM_DEPTH   = 2 * GRID_HEIGHT;
    localparam int RAM_ADDR_W  = $clog2(RAM_DEPTH);
    // Generation sweep reads rows H-1, 0 .. H-1, 0
    localparam int GEN_W       = $clog2(GRID_HEIGHT + 2);

    // Item and result field widths
    localparam int OP_W    = 2;
    localparam int FIELD_W = 6;
    localparam int COUNT_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int THR_W      = 8;
    localparam int LIMIT_W    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RST_LIMIT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SEED_RESET    = 32'h1234_5678;
    localparam logic [THR_W-1:0]      DENSITY_RESET = 8'd230;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET   = 10'd240;

    // Operation codes
    localparam logic [OP_W-1:0] OP_STEP = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL = 2'd2;

    // xorshift32 shift amounts
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
    } lag_item_t;

    typedef struct packed {
        logic               cell_alive;
        logic               refilled;
        logic [COUNT_W-1:0] generation_count;
    } lag_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;       // request accepted, capture address
        logic             rd_en;      // read a row of the current bank
        logic             rd_user;    // address comes from the request
        logic [ROW_W-1:0] rd_row;
        logic             rd_gen;     // read feeds the row window
        logic             rd_emit;    // window full after this row: write result
        logic [ROW_W-1:0] rd_wrow;
        logic             capture;    // latch addressed cell
        logic             flip;       // swap banks at end of a generation
        logic             fill_step;  // one random cell
        logic [COL_W-1:0] fill_col;
        logic             fill_wr;    // row buffer complete
        logic [ROW_W-1:0] fill_row;
        logic             cnt_inc;
        logic             cnt_clr;
        logic             out_load;
        logic             refilled;
    } lag_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_over;
        logic out_free;
    } lag_status_t;

    // One xorshift32 step
    function automatic logic [CFG_DATA_W-1:0] xs32(input logic [CFG_DATA_W-1:0] s);
        logic [CFG_DATA_W-1:0] v;
        begin
            v = s;
            v = v ^ (v << XS_A);
            v = v ^ (v >> XS_B);
            v = v ^ (v << XS_C);
            return v;
        end
    endfunction

    // Next state of one grid row from the rows above, at and below it
    function automatic logic [GRID_WIDTH-1:0] life_row(
        input logic [GRID_WIDTH-1:0] up,
        input logic [GRID_WIDTH-1:0] mid,
        input logic [GRID_WIDTH-1:0] dn
    );
        logic [GRID_WIDTH-1:0] res;
        logic [3:0]            n;
        int                    xl;
        int                    xr;
        begin
            res = '0;
            for (int x = 0; x < GRID_WIDTH; x++)
            begin
                xl = (x == 0) ? GRID_WIDTH - 1 : x - 1;
                xr = (x == GRID_WIDTH - 1) ? 0 : x + 1;
                n  = 4'(up[xl]) + 4'(up[x]) + 4'(up[xr])
                   + 4'(mid[xl]) + 4'(mid[xr])
                   + 4'(dn[xl]) + 4'(dn[x]) + 4'(dn[xr]);
                if (mid[x])
                    res[x] = (n == 4'd2) || (n == 4'd3);
                else
                    res[x] = (n == 4'd3);
            end
            return res;
        end
    endfunction

endpackage

[sv/lag_ram.sv]
// ----------------------------------------------------------------------------
// lag_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lag_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

[sv/lag_ctrl.sv]
// ----------------------------------------------------------------------------
// lag_ctrl
// Sequencer: accepts a request, performs a cell read, walks the row sweep of a
// generation or the cell sweep of a refill, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lag_ctrl
    import lag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [OP_W-1:0]   op,
    output logic              item_stall,
    input  lag_status_t       status,
    output lag_cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_CAPT,
        S_GEN_READ,
        S_GEN_DRAIN_A,
        S_GEN_DRAIN_B,
        S_GEN_END,
        S_FILL,
        S_FINISH
    } state_t;

    localparam logic [GEN_W-1:0] GEN_LAST = GEN_W'(GRID_HEIGHT + 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);

    state_t           state_reg, state_next;
    logic [GEN_W-1:0] k_reg, k_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             refill_reg, refill_next;

    logic             accept;
    logic [GEN_W-1:0] k_minus1;
    logic [GEN_W-1:0] k_minus2;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);
    assign k_minus1   = k_reg - GEN_W'(1);
    assign k_minus2   = k_reg - GEN_W'(2);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        refill_next = refill_reg;
        cmd         = '0;
        cmd.refilled = refill_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load    = 1'b1;
                    refill_next = 1'b0;
                    k_next      = '0;
                    row_next    = '0;
                    col_next    = '0;
                    if (op == OP_STEP)
                        state_next = S_GEN_READ;
                    else if (op == OP_READ)
                        state_next = S_RD_ISSUE;
                    else if (op == OP_FILL)
                    begin
                        refill_next = 1'b1;
                        state_next  = S_FILL;
                    end
                    else
                        state_next = S_FINISH;
                end
            end

            S_RD_ISSUE:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_user = 1'b1;
                state_next  = S_RD_CAPT;
            end

            S_RD_CAPT:
            begin
                cmd.capture = 1'b1;
                state_next  = S_FINISH;
            end

            // Row sweep with wrap: H-1, 0, 1, .., H-1, 0
            S_GEN_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_gen  = 1'b1;
                cmd.rd_emit = (k_reg >= GEN_W'(2));
                cmd.rd_wrow = k_minus2[ROW_W-1:0];
                if (k_reg == '0)
                    cmd.rd_row = ROW_LAST;
                else if (k_reg == GEN_LAST)
                    cmd.rd_row = '0;
                else
                    cmd.rd_row = k_minus1[ROW_W-1:0];
                if (k_reg == GEN_LAST)
                    state_next = S_GEN_DRAIN_A;
                else
                    k_next = k_reg + GEN_W'(1);
            end

            S_GEN_DRAIN_A:
                state_next = S_GEN_DRAIN_B;

            S_GEN_DRAIN_B:
                state_next = S_GEN_END;

            S_GEN_END:
            begin
                cmd.flip = 1'b1;
                if (status.cnt_over)
                begin
                    refill_next = 1'b1;
                    row_next    = '0;
                    col_next    = '0;
                    state_next  = S_FILL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end

            // One random cell per cycle, row-major
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_col  = col_reg;
                cmd.fill_row  = row_reg;
                cmd.fill_wr   = (col_reg == COL_LAST);
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                    if (row_reg == ROW_LAST)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_FINISH;
                    end
                end
                else
                    col_next = col_reg + COL_W'(1);
            end

            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            refill_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            refill_reg <= refill_next;
        end
    end

endmodule

[sv/lag_dpath.sv]
// ----------------------------------------------------------------------------
// lag_dpath
// Datapath: two-bank row memory, three-row window with the Life rule,
// xorshift32 refill generator, configuration, counter and result register.
// ----------------------------------------------------------------------------
module lag_dpath
    import lag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lag_item_t             item,
    input  lag_cmd_t              cmd,
    output lag_status_t           status,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lag_result_t           result
);

    // Configuration and state
    logic [THR_W-1:0]      thr_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [CFG_DATA_W-1:0] rnd_reg, rnd_next;
    logic [COUNT_W-1:0]    cnt_reg;
    logic                  bank_reg;
    logic [1:0]            bank_valid_reg;

    // Request address
    logic [FIELD_W-1:0]    row_reg;
    logic [FIELD_W-1:0]    col_reg;
    logic                  in_range_reg;
    logic                  alive_reg;

    // Read pipeline and row window
    logic                  rdp_gen_reg;
    logic                  rdp_emit_reg;
    logic [ROW_W-1:0]      rdp_wrow_reg;
    logic                  wr_pend_reg;
    logic [ROW_W-1:0]      wr_row_reg;
    logic [GRID_WIDTH-1:0] win_up_reg;
    logic [GRID_WIDTH-1:0] win_mid_reg;
    logic [GRID_WIDTH-1:0] win_dn_reg;

    // Refill row buffer
    logic [GRID_WIDTH-1:0] fill_buf_reg, fill_buf_next;
    logic                  fill_bit;

    // Output register
    logic                  out_valid_reg;
    lag_result_t           out_reg;

    // Memory ports
    logic                  ram_wr_en;
    logic [RAM_ADDR_W-1:0] ram_wr_addr;
    logic [GRID_WIDTH-1:0] ram_wr_data;
    logic [RAM_ADDR_W-1:0] ram_rd_addr;
    logic [GRID_WIDTH-1:0] ram_rd_data;
    logic [GRID_WIDTH-1:0] rd_masked;
    logic [ROW_W-1:0]      rd_row_sel;
    logic [ROW_W-1:0]      user_row;
    logic [COL_W-1:0]      user_col;

    assign user_row   = ROW_W'(row_reg);
    assign user_col   = COL_W'(col_reg);
    assign rd_row_sel = cmd.rd_user ? user_row : cmd.rd_row;
    assign ram_rd_addr = {bank_reg, rd_row_sel};

    // Rows of a bank never written since reset read as dead
    assign rd_masked = bank_valid_reg[bank_reg] ? ram_rd_data : '0;

    // Random cell for the refill sweep
    assign rnd_next = xs32(rnd_reg);
    assign fill_bit = (rnd_next[THR_W-1:0] > thr_reg);

    always_comb
    begin
        fill_buf_next = fill_buf_reg;
        fill_buf_next[cmd.fill_col] = fill_bit;
    end

    // Write port: generation result into the other bank, refill into current
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = {bank_reg, cmd.fill_row};
        ram_wr_data = fill_buf_next;
        if (wr_pend_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {~bank_reg, wr_row_reg};
            ram_wr_data = life_row(win_up_reg, win_mid_reg, win_dn_reg);
        end
        else if (cmd.fill_step && cmd.fill_wr)
            ram_wr_en = 1'b1;
    end

    lag_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Status
    assign status.cnt_over = (cnt_reg > COUNT_W'(limit_reg));
    assign status.out_free = !out_valid_reg || !result_stall;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= DENSITY_RESET;
            limit_reg      <= LIMIT_RESET;
            rnd_reg        <= SEED_RESET;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            bank_valid_reg <= '0;
            rdp_gen_reg    <= 1'b0;
            rdp_emit_reg   <= 1'b0;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SEED:      rnd_reg   <= cfg_wdata;
                    REG_DENSITY:   thr_reg   <= cfg_wdata[THR_W-1:0];
                    REG_RST_LIMIT: limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:       ;
                endcase
            end
            else if (cmd.fill_step)
                rnd_reg <= rnd_next;

            // Generation counter
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + COUNT_W'(1);

            // Bank swap and fill tracking
            if (cmd.flip)
            begin
                bank_reg                  <= ~bank_reg;
                bank_valid_reg[~bank_reg] <= 1'b1;
            end
            if (cmd.fill_step)
                bank_valid_reg[bank_reg] <= 1'b1;

            // Read pipeline tags
            rdp_gen_reg  <= cmd.rd_en && cmd.rd_gen;
            rdp_emit_reg <= cmd.rd_en && cmd.rd_emit;
            wr_pend_reg  <= rdp_gen_reg && rdp_emit_reg;

            // Result register
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg      <= item.row;
            col_reg      <= item.col;
            in_range_reg <= (32'(item.row) < GRID_HEIGHT) && (32'(item.col) < GRID_WIDTH);
            alive_reg    <= 1'b0;
        end
        else if (cmd.capture)
            alive_reg <= in_range_reg && rd_masked[user_col];

        rdp_wrow_reg <= cmd.rd_wrow;
        if (rdp_gen_reg)
        begin
            win_up_reg  <= win_mid_reg;
            win_mid_reg <= win_dn_reg;
            win_dn_reg  <= rd_masked;
            wr_row_reg  <= rdp_wrow_reg;
        end

        if (cmd.fill_step)
            fill_buf_reg <= fill_buf_next;

        if (cmd.out_load)
        begin
            out_reg.cell_alive       <= alive_reg;
            out_reg.refilled         <= cmd.refilled;
            out_reg.generation_count <= cnt_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[sv/life_automaton_grid.sv]
// From acceptance to result_valid, a read passes S_RD_ISSUE, S_RD_CAPT and S_FINISH, an
// unused op goes to S_FINISH, a generation sweeps rows H-1, 0 .. H-1, 0 and drains, and a
// refill writes every cell; a generation that restarts also runs the refill sweep. One
// request at a time: the next is taken once its result loads into the output register.
// Refill draws one xorshift32 value per cycle; a generation reads one 64-cell row per cycle.
// Reset: asynchronous; grid reads as all dead at once (per-bank fill flags), seed loaded.
// ----------------------------------------------------------------------------
// life_automaton_grid
// Toroidal Conway's Life grid with random refill, top level.
// ----------------------------------------------------------------------------
module life_automaton_grid
    import lag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  lag_item_t             item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lag_result_t           result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    lag_cmd_t    cmd;
    lag_status_t status;

    // Sequencer
    lag_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .op         (item.op),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Storage and arithmetic
    lag_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sv/lag_checker.sv]
// ----------------------------------------------------------------------------
// lag_checker
// Port-level checks for the Life grid, bound to the top level.
// ----------------------------------------------------------------------------
module lag_checker
    import lag_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input lag_result_t           result
);

    // Stalled result stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A cell read never refills
    a_read_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.cell_alive |-> !result.refilled)
        else $error("live cell reported on a refill");

    // Refill clears the counter
    a_refill_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.refilled |-> result.generation_count == '0)
        else $error("refill without counter clear");

    // Counter never passes the largest restart limit plus one
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.generation_count <= COUNT_W'(1024))
        else $error("generation count out of range");

    // A new request is taken only after the previous result has been produced
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request taken while busy");

endmodule

bind life_automaton_grid lag_checker u_lag_checker (.*);
